// ===== rtl/fpit_pkg.sv =====
// Package for the six-plane frustum point test.
// Holds the control word that travels with each item down the chain of plane cells.
// No dependencies.
`default_nettype none

package fpit_pkg;

	// Codes carried on s_tuser.
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// Control flags that ride alongside each item through the cell chain.
	typedef struct packed {
		logic valid;     // stage holds an item
		logic query;     // item is a point query, not a plane load
		logic in_bounds; // no cell so far has found the point on its outer side
		logic loaded;    // every cell so far holds a loaded plane
	} ctl_t;

	// Result transfer layout.
	localparam int OUT_TDATA_W = 8;
	localparam int RES_INSIDE_BIT = 0;
	localparam int RES_READY_BIT = 1;

	// Width of the plane index field at the default plane count.
	localparam int MIN_IDX_W = 3;

endpackage

`default_nettype wire

// ===== rtl/frustum_point_inside_test_top.sv =====
// Top level of the six-plane frustum point test: a chain of plane cells and a result register.
// Depends on fpit_pkg and fpit_cell.
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: action; tdata: plane_index, normals, point
// m_*       out  m_tvalid/m_tready  tdata: inside_res, frustum_ready
//
// Flow: one item is taken every cycle while the chain is not stalled. A query's result is
// registered through three register stages in each plane cell (difference, products, sum
// and sign test), and then through the result register.
// Loads give no result; they write their plane as they pass the matching cell, so a later
// query always sees every earlier load.
// Reset clears the stage valid bits, the per-cell loaded bits and the result register; the
// plane values themselves hold no reset and are trusted only once loaded.
// Stalls: the chain holds only when a query reaches its end while the result register is
// full and not being taken; at all other times new transfers are accepted.

module frustum_point_inside_test_top #(
	parameter int PLANE_COUNT = 6,
	parameter int COORD_WIDTH = 32,
	parameter int NORMAL_WIDTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,

	input  wire logic s_tvalid,
	output logic      s_tready,
	// action (0 = load plane, 1 = query point)
	input  wire logic s_tuser,
	// from bit 0: plane_index, normal_x, normal_y, normal_z, point_x, point_y, point_z, zero pad
	input  wire logic [((((PLANE_COUNT > 8) ? $clog2(PLANE_COUNT) : 3)
		+ 3*NORMAL_WIDTH + 3*COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,

	output logic      m_tvalid,
	input  wire logic m_tready,
	// from bit 0: inside_res, frustum_ready, zero pad
	output logic [fpit_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam int IDX_W = (PLANE_COUNT > 8) ? $clog2(PLANE_COUNT) : fpit_pkg::MIN_IDX_W;
	localparam int NOFF = IDX_W;
	localparam int POFF = IDX_W + 3*NORMAL_WIDTH;

	// Chain links: entry i feeds cell i.
	fpit_pkg::ctl_t          ctl_c [PLANE_COUNT];
	logic [IDX_W-1:0]        idx_c [PLANE_COUNT];
	logic [3*NORMAL_WIDTH-1:0] nrm_c [PLANE_COUNT];
	logic [3*COORD_WIDTH-1:0]  pnt_c [PLANE_COUNT];
	fpit_pkg::ctl_t          ctl_end;
	fpit_pkg::ctl_t          ctl_head;

	logic en;
	logic push;
	logic out_valid_q;
	logic inside_q;
	logic ready_q;

	// The chain advances unless a finished query would overrun a held result.
	assign en = !(ctl_end.valid && ctl_end.query && out_valid_q && !m_tready);
	assign push = en && ctl_end.valid && ctl_end.query;
	assign s_tready = en;

	// A new item enters with no plane yet tested against it.
	always_comb begin
		ctl_head.valid = s_tvalid;
		ctl_head.query = (s_tuser == fpit_pkg::ACT_QUERY);
		ctl_head.in_bounds = 1'b1;
		ctl_head.loaded = 1'b1;
	end
	assign ctl_c[0] = ctl_head;
	assign idx_c[0] = s_tdata[IDX_W-1:0];
	assign nrm_c[0] = s_tdata[NOFF +: 3*NORMAL_WIDTH];
	assign pnt_c[0] = s_tdata[POFF +: 3*COORD_WIDTH];

	for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
		if (i < PLANE_COUNT - 1) begin : g_mid
			fpit_cell #(
				.PLANE_ID(i),
				.CW(COORD_WIDTH),
				.NW(NORMAL_WIDTH),
				.IDX_W(IDX_W)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.en(en),
				.ctl_in(ctl_c[i]),
				.idx_in(idx_c[i]),
				.nrm_in(nrm_c[i]),
				.pnt_in(pnt_c[i]),
				.ctl_out(ctl_c[i+1]),
				.idx_out(idx_c[i+1]),
				.nrm_out(nrm_c[i+1]),
				.pnt_out(pnt_c[i+1])
			);
		end else begin : g_last
			// The last cell's pass-through data has no further consumer.
			fpit_cell #(
				.PLANE_ID(i),
				.CW(COORD_WIDTH),
				.NW(NORMAL_WIDTH),
				.IDX_W(IDX_W)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.en(en),
				.ctl_in(ctl_c[i]),
				.idx_in(idx_c[i]),
				.nrm_in(nrm_c[i]),
				.pnt_in(pnt_c[i]),
				.ctl_out(ctl_end),
				.idx_out(),
				.nrm_out(),
				.pnt_out()
			);
		end
	end

	// Result register. A query with any unloaded plane reports not inside.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			inside_q <= 1'b0;
			ready_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
			inside_q <= ctl_end.loaded & ctl_end.in_bounds;
			ready_q <= ctl_end.loaded;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	always_comb begin
		m_tdata = '0;
		m_tdata[fpit_pkg::RES_INSIDE_BIT] = inside_q;
		m_tdata[fpit_pkg::RES_READY_BIT] = ready_q;
	end

	// A result is never written over one that has not been transferred.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!out_valid_q || m_tready))
		else $error("result register overrun");

	// The input side only stalls behind a held, untaken result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without a blocked result");

	// An inside verdict is only given by a fully loaded frustum.
	a_inside_needs_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[fpit_pkg::RES_INSIDE_BIT] && !m_tdata[fpit_pkg::RES_READY_BIT]))
		else $error("inside reported before all planes loaded");

endmodule

`default_nettype wire

// ===== rtl/fpit_cell.sv =====
// One plane cell of the frustum test chain: stores one plane and tests passing queries.
// Three register stages per cell (difference, products, sum and sign).
// Depends on fpit_pkg.
`default_nettype none

module fpit_cell #(
	parameter int PLANE_ID = 0,
	parameter int CW = 32,
	parameter int NW = 16,
	parameter int IDX_W = 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire fpit_pkg::ctl_t    ctl_in,
	input  wire logic [IDX_W-1:0]  idx_in,
	input  wire logic [3*NW-1:0]   nrm_in,
	input  wire logic [3*CW-1:0]   pnt_in,
	output fpit_pkg::ctl_t         ctl_out,
	output logic [IDX_W-1:0]       idx_out,
	output logic [3*NW-1:0]        nrm_out,
	output logic [3*CW-1:0]        pnt_out
);

	localparam int DW = CW + 1;
	localparam int PW = DW + NW;
	localparam int SW = PW + 2;

	// Plane held by this cell.
	logic signed [NW-1:0] nrm_q [3];
	logic signed [CW-1:0] pnt_q [3];
	logic                 loaded_q;

	logic wr;
	assign wr = en && ctl_in.valid && !ctl_in.query && (idx_in == IDX_W'(PLANE_ID));

	// Stage registers.
	fpit_pkg::ctl_t       ctl_s1, ctl_s2, ctl_s3;
	logic [IDX_W-1:0]     idx_s1, idx_s2, idx_s3;
	logic [3*NW-1:0]      nrm_s1, nrm_s2, nrm_s3;
	logic [3*CW-1:0]      pnt_s1, pnt_s2, pnt_s3;
	logic signed [DW-1:0] diff_s1 [3];
	logic signed [NW-1:0] wn_s1 [3];
	logic signed [PW-1:0] prod_s2 [3];

	logic signed [DW-1:0] diff [3];
	logic signed [SW-1:0] sum;
	logic                 outer;
	fpit_pkg::ctl_t       ctl_to_s1, ctl_to_s3;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			diff[k] = $signed({pnt_in[k*CW+CW-1], pnt_in[k*CW +: CW]})
				- $signed({pnt_q[k][CW-1], pnt_q[k]});
		end
	end

	always_comb begin
		sum = $signed({{2{prod_s2[0][PW-1]}}, prod_s2[0]})
			+ $signed({{2{prod_s2[1][PW-1]}}, prod_s2[1]})
			+ $signed({{2{prod_s2[2][PW-1]}}, prod_s2[2]});
		outer = !sum[SW-1] && (sum != '0);
	end

	// Control words entering the first and last stage, with this cell's findings merged in.
	always_comb begin
		ctl_to_s1 = ctl_in;
		ctl_to_s1.loaded = ctl_in.loaded & loaded_q;
		ctl_to_s3 = ctl_s2;
		ctl_to_s3.in_bounds = ctl_s2.in_bounds & ~outer;
	end

	// The plane store has no reset: it is only trusted once its loaded bit is set.
	always_ff @(posedge clk) begin
		if (wr) begin
			for (int k = 0; k < 3; k++) begin
				nrm_q[k] <= nrm_in[k*NW +: NW];
				pnt_q[k] <= pnt_in[k*CW +: CW];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			if (wr) begin
				loaded_q <= 1'b1;
			end
			ctl_s1 <= ctl_to_s1;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_to_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1 <= idx_in;
			nrm_s1 <= nrm_in;
			pnt_s1 <= pnt_in;
			idx_s2 <= idx_s1;
			nrm_s2 <= nrm_s1;
			pnt_s2 <= pnt_s1;
			idx_s3 <= idx_s2;
			nrm_s3 <= nrm_s2;
			pnt_s3 <= pnt_s2;
			for (int k = 0; k < 3; k++) begin
				diff_s1[k] <= diff[k];
				wn_s1[k] <= nrm_q[k];
				prod_s2[k] <= diff_s1[k] * wn_s1[k];
			end
		end
	end

	assign ctl_out = ctl_s3;
	assign idx_out = idx_s3;
	assign nrm_out = nrm_s3;
	assign pnt_out = pnt_s3;

endmodule

`default_nettype wire
